// ----- hw/rtl/rsum_pkg.sv -----
// shared constants, codes and types of the range sum tree
package rsum_pkg;

	// tree geometry
	localparam int LEAVES  = 1024;
	localparam int LEAF_AW = $clog2(LEAVES);
	localparam int SZ      = 1 << LEAF_AW;
	localparam int NODES   = 2 * SZ;
	localparam int NODE_W  = LEAF_AW + 1;
	localparam int BND_W   = NODE_W + 1;

	// request field widths
	localparam int TYPE_W = 2;
	localparam int IDX_W  = 10;
	localparam int VAL_W  = 48;

	// request kinds
	localparam logic [TYPE_W-1:0] REQ_SET   = 2'd0;
	localparam logic [TYPE_W-1:0] REQ_SUB   = 2'd1;
	localparam logic [TYPE_W-1:0] REQ_QUERY = 2'd2;

	// datapath commands
	typedef logic [3:0] dp_op_t;
	localparam dp_op_t DP_NOP        = 4'd0;
	localparam dp_op_t DP_CLR_STEP   = 4'd1;
	localparam dp_op_t DP_CAPTURE    = 4'd2;
	localparam dp_op_t DP_LEAF_WR    = 4'd3;
	localparam dp_op_t DP_LEAF_RD    = 4'd4;
	localparam dp_op_t DP_LEAF_SUB   = 4'd5;
	localparam dp_op_t DP_SIB_RD     = 4'd6;
	localparam dp_op_t DP_PARENT_WR  = 4'd7;
	localparam dp_op_t DP_Q_INIT     = 4'd8;
	localparam dp_op_t DP_Q_RD       = 4'd9;
	localparam dp_op_t DP_Q_ACC      = 4'd10;
	localparam dp_op_t DP_RESULT     = 4'd11;

	// datapath status seen by the controller
	typedef struct packed {
		logic              clr_last;
		logic [TYPE_W-1:0] kind;
		logic              in_range;
		logic              q_empty;
		logic              at_root;
		logic              q_more;
	} sts_t;

endpackage

// ----- hw/rtl/rsum_dp.sv -----
// datapath of the range sum tree: node memory, walk registers, accumulator
module rsum_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rsum_pkg::dp_op_t                    cmd_op,
	output rsum_pkg::sts_t                      sts,
	input  logic [rsum_pkg::TYPE_W-1:0]         req_type,
	input  logic [rsum_pkg::IDX_W-1:0]          index,
	input  logic [rsum_pkg::IDX_W-1:0]          right_bound,
	input  logic signed [rsum_pkg::VAL_W-1:0]   value,
	output logic signed [rsum_pkg::VAL_W-1:0]   sum
);
	import rsum_pkg::*;

	logic [VAL_W-1:0]  mem [NODES];

	logic [TYPE_W-1:0] typ_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  rgt_q;
	logic [VAL_W-1:0]  val_q;

	logic [NODE_W-1:0] node_q;
	logic [VAL_W-1:0]  cur_q;
	logic [BND_W-1:0]  a_q;
	logic [BND_W-1:0]  b_q;
	logic              fa_q;
	logic              fb_q;
	logic [VAL_W-1:0]  acc_q;
	logic [VAL_W-1:0]  sum_q;
	logic [VAL_W-1:0]  rd0_q;
	logic [VAL_W-1:0]  rd1_q;

	logic [IDX_W-1:0]  rgt_clip;
	logic [NODE_W-1:0] leaf_node;
	logic [NODE_W-1:0] ra0;
	logic [NODE_W-1:0] ra1;
	logic              we;
	logic [NODE_W-1:0] wa;
	logic [VAL_W-1:0]  wd;
	logic [VAL_W-1:0]  sub_val;
	logic [VAL_W-1:0]  par_val;
	logic [VAL_W-1:0]  acc_nxt;

	// request decode
	assign rgt_clip  = (32'(rgt_q) >= LEAVES) ? IDX_W'(LEAVES - 1) : rgt_q;
	assign leaf_node = NODE_W'(SZ) + NODE_W'(idx_q);
	assign sub_val   = rd0_q - val_q;
	assign par_val   = cur_q + rd0_q;
	assign acc_nxt   = acc_q + (fa_q ? rd0_q : '0) + (fb_q ? rd1_q : '0);

	assign sts.clr_last = (node_q == NODE_W'(NODES - 1));
	assign sts.kind     = typ_q;
	assign sts.in_range = (32'(idx_q) < LEAVES);
	assign sts.q_empty  = (idx_q > rgt_clip);
	assign sts.at_root  = (node_q == NODE_W'(1));
	assign sts.q_more   = (a_q < b_q);

	// memory port addresses and write data
	always_comb begin
		we  = 1'b0;
		wa  = node_q;
		wd  = '0;
		ra0 = node_q;
		ra1 = NODE_W'(b_q - BND_W'(1));
		unique case (cmd_op)
			DP_CLR_STEP: begin
				we = 1'b1;
			end
			DP_LEAF_WR: begin
				we = 1'b1;
				wa = leaf_node;
				wd = val_q;
			end
			DP_LEAF_RD: begin
				ra0 = leaf_node;
			end
			DP_LEAF_SUB: begin
				we = 1'b1;
				wd = sub_val;
			end
			DP_SIB_RD: begin
				ra0 = node_q ^ NODE_W'(1);
			end
			DP_PARENT_WR: begin
				we = 1'b1;
				wa = node_q >> 1;
				wd = par_val;
			end
			DP_Q_RD: begin
				ra0 = NODE_W'(a_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd0_q <= mem[ra0];
		rd1_q <= mem[ra1];
	end

	// node pointer doubles as the clearing sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q <= '0;
		end else begin
			unique case (cmd_op)
				DP_CLR_STEP:  node_q <= node_q + NODE_W'(1);
				DP_LEAF_WR:   node_q <= leaf_node;
				DP_LEAF_RD:   node_q <= leaf_node;
				DP_PARENT_WR: node_q <= node_q >> 1;
				default:      node_q <= node_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd_op)
			DP_CAPTURE: begin
				typ_q <= req_type;
				idx_q <= index;
				rgt_q <= right_bound;
				val_q <= value;
				acc_q <= '0;
			end
			DP_LEAF_WR:   cur_q <= val_q;
			DP_LEAF_SUB:  cur_q <= sub_val;
			DP_PARENT_WR: cur_q <= par_val;
			DP_Q_INIT: begin
				a_q <= BND_W'(SZ) + BND_W'(idx_q);
				b_q <= BND_W'(SZ) + BND_W'(rgt_clip) + BND_W'(1);
			end
			DP_Q_RD: begin
				fa_q <= a_q[0];
				fb_q <= b_q[0];
				a_q  <= (a_q + BND_W'(a_q[0])) >> 1;
				b_q  <= (b_q - BND_W'(b_q[0])) >> 1;
			end
			DP_Q_ACC:  acc_q <= acc_nxt;
			DP_RESULT: sum_q <= acc_q;
			default: begin
			end
		endcase
	end

	assign sum = sum_q;

	// query bounds never cross
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_op == DP_Q_RD && a_q < b_q) |=> (a_q <= b_q))
		else $error("query bounds crossed");

	// a parent write never climbs past the root
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_op == DP_PARENT_WR) |=> (node_q != '0))
		else $error("update walk left the tree");

endmodule

// ----- hw/rtl/rsum_ctrl.sv -----
// controller state machine of the range sum tree
module rsum_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output rsum_pkg::dp_op_t  cmd_op,
	input  rsum_pkg::sts_t    sts
);
	import rsum_pkg::*;

	localparam logic [3:0] S_CLEAR  = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_DECODE = 4'd2;
	localparam logic [3:0] S_SUB_WR = 4'd3;
	localparam logic [3:0] S_UP_RD  = 4'd4;
	localparam logic [3:0] S_UP_WR  = 4'd5;
	localparam logic [3:0] S_Q_RD   = 4'd6;
	localparam logic [3:0] S_Q_ACC  = 4'd7;
	localparam logic [3:0] S_DONE   = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_nxt;
	logic       rsp_valid_q;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_nxt = state_q;
		cmd_op    = DP_NOP;
		unique case (state_q)
			S_CLEAR: begin
				cmd_op = DP_CLR_STEP;
				if (sts.clr_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd_op    = DP_CAPTURE;
					state_nxt = S_DECODE;
				end
			end
			S_DECODE: begin
				priority if (sts.kind == REQ_SET && sts.in_range) begin
					cmd_op    = DP_LEAF_WR;
					state_nxt = S_UP_RD;
				end else if (sts.kind == REQ_SUB && sts.in_range) begin
					cmd_op    = DP_LEAF_RD;
					state_nxt = S_SUB_WR;
				end else if (sts.kind == REQ_QUERY && !sts.q_empty) begin
					cmd_op    = DP_Q_INIT;
					state_nxt = S_Q_RD;
				end else begin
					state_nxt = S_DONE;
				end
			end
			S_SUB_WR: begin
				cmd_op    = DP_LEAF_SUB;
				state_nxt = S_UP_RD;
			end
			S_UP_RD: begin
				if (sts.at_root) begin
					state_nxt = S_DONE;
				end else begin
					cmd_op    = DP_SIB_RD;
					state_nxt = S_UP_WR;
				end
			end
			S_UP_WR: begin
				cmd_op    = DP_PARENT_WR;
				state_nxt = S_UP_RD;
			end
			S_Q_RD: begin
				if (sts.q_more) begin
					cmd_op    = DP_Q_RD;
					state_nxt = S_Q_ACC;
				end else begin
					state_nxt = S_DONE;
				end
			end
			S_Q_ACC: begin
				cmd_op    = DP_Q_ACC;
				state_nxt = S_Q_RD;
			end
			S_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					cmd_op    = DP_RESULT;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd_op == DP_RESULT) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// no result can appear while the store is being cleared
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !rsp_valid_q)
		else $error("result during clearing pass");

	// a waiting result is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && rsp_valid_q && rsp_stall) |=> (state_q == S_DONE))
		else $error("result register overwritten");

	// the update walk only reads a sibling below the root
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UP_WR) |-> $past(!sts.at_root))
		else $error("sibling read at root");

endmodule

// ----- hw/rtl/range_sum_tree_unit.sv -----
// top level of the range sum tree: controller and datapath
// A sum tree over LEAVES (1024) signed 48-bit leaves held in a 2048-entry node
// memory with one write port and two registered read ports. After reset the
// unit runs a clearing pass over the node memory, during which req_stall
// stays high. Requests are handled one at a time: a set writes the leaf and
// then walks up the tree, spending a sibling read and a parent write on each
// of the ten tree levels; a subtract first reads the leaf and writes the
// difference before the same walk. A query spends a read step and an
// accumulate step per level for up to eleven levels; an empty or out-of-range
// request goes straight to a zero result. Every request gives exactly one
// result transfer on the rsp channel (zero for set and subtract). The result
// sits in an output register, so the next request is taken while an earlier
// result still waits for the consumer.
module range_sum_tree_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic [rsum_pkg::TYPE_W-1:0]         req_type,
	input  logic [rsum_pkg::IDX_W-1:0]          index,
	input  logic [rsum_pkg::IDX_W-1:0]          right_bound,
	input  logic signed [rsum_pkg::VAL_W-1:0]   value,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output logic signed [rsum_pkg::VAL_W-1:0]   sum
);
	import rsum_pkg::*;

	// command from the state machine, status back from the datapath
	dp_op_t cmd_op;
	sts_t   sts;

	rsum_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd_op    (cmd_op),
		.sts       (sts)
	);

	rsum_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_op      (cmd_op),
		.sts         (sts),
		.req_type    (req_type),
		.index       (index),
		.right_bound (right_bound),
		.value       (value),
		.sum         (sum)
	);

endmodule

// ----- bench/tb_range_sum_tree_unit.sv -----
// testbench for range_sum_tree_unit: directed and random set, subtract, query and unused-type requests
`timescale 1ns / 1ps

module tb_range_sum_tree_unit;
	import rsum_pkg::*;

	// request type 3 has no meaning in the block; it must leave the tree alone
	localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;

	localparam int RANDOM_REQS   = 1800;
	localparam int IDLE_LIMIT    = 20000;  // must outlast the clearing pass after reset
	localparam int SETTLE_CYCLES = 64;     // settle time after the last result

	localparam logic [VAL_W-1:0] VAL_MAX  = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic [VAL_W-1:0] VAL_MIN  = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic [VAL_W-1:0] VAL_ONES = {VAL_W{1'b1}};
	localparam logic [VAL_W-1:0] VAL_ZERO = {VAL_W{1'b0}};
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(LEAVES - 1);

	// one pending request plus the idle cycles the sender spends after it
	typedef struct {
		logic [TYPE_W-1:0] kind;
		logic [IDX_W-1:0]  left;
		logic [IDX_W-1:0]  right;
		logic [VAL_W-1:0]  val;
		int unsigned       gap;
		bit                drain;  // hold off until every result so far has come back
	} tree_req_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     req_valid = 1'b0;
	logic                     req_stall;
	logic [TYPE_W-1:0]        req_type = REQ_SET;
	logic [IDX_W-1:0]         index = '0;
	logic [IDX_W-1:0]         right_bound = '0;
	logic signed [VAL_W-1:0]  value = '0;
	logic                     rsp_valid;
	logic                     rsp_stall = 1'b0;
	logic signed [VAL_W-1:0]  sum;

	// shadow copy of the node memory: node 1 is the root, leaf i sits at SZ+i
	logic [VAL_W-1:0] node_sum [NODES];

	tree_req_t        pending_reqs[$];
	logic [VAL_W-1:0] sum_expect[$];

	int          errs = 0;
	int          idle_cycles = 0;
	int unsigned accepted_reqs = 0;
	int unsigned rsp_count = 0;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	bit          calm = 1'b0;
	logic [IDX_W-1:0] hot_base = '0;

	range_sum_tree_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_type    (req_type),
		.index       (index),
		.right_bound (right_bound),
		.value       (value),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.sum         (sum)
	);

	always #2 clk = ~clk;

	// rewrite one leaf and every ancestor on the way up to the root
	function automatic void leaf_write(int unsigned leaf, logic [VAL_W-1:0] v);
		int unsigned k;
		k = leaf + SZ;
		node_sum[k] = v;
		for (k = k >> 1; k != 0; k = k >> 1)
			node_sum[k] = node_sum[2*k] + node_sum[2*k+1];
	endfunction

	// bottom-up walk over the nodes that exactly cover [lo, hi]; wraps at 48 bits
	function automatic logic [VAL_W-1:0] span_sum(int unsigned lo, int unsigned hi);
		logic [VAL_W-1:0] acc;
		int unsigned a, b;
		acc = '0;
		a = lo + SZ;
		b = hi + SZ + 1;
		while (a < b) begin
			if ((a & 1) != 0) begin
				acc += node_sum[a];
				a++;
			end
			if ((b & 1) != 0) begin
				b--;
				acc += node_sum[b];
			end
			a = a >> 1;
			b = b >> 1;
		end
		return acc;
	endfunction

	// updates the shadow tree for one request and gives the sum it must return
	function automatic logic [VAL_W-1:0] tree_request(logic [TYPE_W-1:0] kind,
			logic [IDX_W-1:0] left, logic [IDX_W-1:0] right, logic [VAL_W-1:0] val);
		int unsigned hi;
		logic [VAL_W-1:0] res;
		res = '0;
		// right bound clips to the last leaf; a left bound past it covers nothing
		hi = (right >= LEAVES) ? LEAVES - 1 : right;
		case (kind)
		REQ_SET: begin
			if (left < LEAVES)
				leaf_write(left, val);
		end
		REQ_SUB: begin
			if (left < LEAVES)
				leaf_write(left, node_sum[left + SZ] - val);
		end
		REQ_QUERY: begin
			if (left <= hi && left < LEAVES)
				res = span_sum(left, hi);
		end
		default: begin
			// unused request type: no state change, zero result
		end
		endcase
		return res;
	endfunction

	function automatic void add_req(logic [TYPE_W-1:0] kind, logic [IDX_W-1:0] left,
			logic [IDX_W-1:0] right, logic [VAL_W-1:0] val, bit drain = 1'b0);
		tree_req_t r;
		r.kind  = kind;
		r.left  = left;
		r.right = right;
		r.val   = val;
		r.gap   = calm ? 0 : $urandom_range(0, 4);
		r.drain = drain;
		pending_reqs.push_back(r);
	endfunction

	// mix of full-width, small signed and extreme values
	function automatic logic [VAL_W-1:0] rand_val();
		logic [63:0] raw;
		int unsigned pick;
		raw = {$urandom, $urandom};
		pick = $urandom_range(0, 9);
		if (pick < 4)
			return raw[VAL_W-1:0];
		else if (pick < 8)
			return {{(VAL_W-12){raw[11]}}, raw[11:0]};
		else if (pick == 8)
			return raw[0] ? VAL_MAX : VAL_MIN;
		else
			return raw[0] ? VAL_ONES : VAL_ZERO;
	endfunction

	// a third of the indexes land in a small window so queries see recent updates
	function automatic logic [IDX_W-1:0] rand_idx();
		if ($urandom_range(0, 2) == 0)
			return hot_base + IDX_W'($urandom_range(0, 15));
		return IDX_W'($urandom_range(0, LEAVES - 1));
	endfunction

	// request side: presents queued transfers, predicts each one as it is taken
	always @(posedge clk or negedge arst_n) begin : req_driver
		tree_req_t nxt;
		logic fire;
		if (!arst_n) begin
			req_valid <= 1'b0;
			gap_left = 0;
		end else begin
			fire = req_valid && !req_stall;
			if (fire) begin
				sum_expect.push_back(tree_request(req_type, index, right_bound, value));
				accepted_reqs++;
			end
			// payload only moves once the current transfer is done
			if (fire || !req_valid) begin
				if (gap_left != 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else if (pending_reqs.size() != 0 &&
						(!pending_reqs[0].drain || sum_expect.size() == 0)) begin
					nxt = pending_reqs.pop_front();
					req_type    <= nxt.kind;
					index       <= nxt.left;
					right_bound <= nxt.right;
					value       <= nxt.val;
					req_valid   <= 1'b1;
					gap_left = nxt.gap;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// result side: checks each transfer against the oldest expected sum
	always @(posedge clk or negedge arst_n) begin : rsp_monitor
		logic [VAL_W-1:0] want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (sum_expect.size() == 0) begin
					errs++;
					$display("%0t: unexpected result, expected none actual %0d", $time, sum);
				end else begin
					want = sum_expect.pop_front();
					if (sum !== want) begin
						errs++;
						$display("%0t: sum mismatch, expected %0d actual %0d",
							$time, $signed(want), sum);
					end
				end
				rsp_count++;
				// every fourth stretch of results goes through with no stall
				stall_left = ((rsp_count / 128) % 4 == 1) ? 0 : $urandom_range(0, 4);
			end else if (rsp_valid && rsp_stall && stall_left != 0) begin
				stall_left--;
			end
			// stall is raised ahead so it lands on the next result when it shows up
			rsp_stall <= (stall_left != 0);
		end
	end

	// watchdog: too long with no transfer on either channel means a hang
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		int unsigned n, pick, qsel, total;
		logic [IDX_W-1:0] a, b, t;
		foreach (node_sum[i])
			node_sum[i] = '0;

		// directed part: extremes, wrap-around, empty ranges, the unused type
		add_req(REQ_QUERY, '0, IDX_LAST, rand_val());        // whole tree while empty
		add_req(REQ_SET, '0, IDX_LAST, VAL_MAX);
		add_req(REQ_SET, IDX_LAST, '0, VAL_MIN);
		add_req(REQ_QUERY, '0, IDX_LAST, VAL_ZERO);          // max + min
		add_req(REQ_QUERY, '0, '0, VAL_ONES);
		add_req(REQ_QUERY, IDX_LAST, IDX_LAST, VAL_ZERO);
		add_req(REQ_SET, IDX_W'(511), IDX_LAST, VAL_ONES);
		add_req(REQ_SET, IDX_W'(512), '0, VAL_W'(1));
		add_req(REQ_QUERY, IDX_W'(511), IDX_W'(512), VAL_ZERO);  // straddles the root split
		add_req(REQ_QUERY, IDX_W'(1), IDX_W'(1022), VAL_ZERO);
		add_req(REQ_SUB, '0, '0, VAL_MIN);                   // max - min wraps
		add_req(REQ_QUERY, '0, '0, VAL_ZERO);
		add_req(REQ_SUB, IDX_W'(700), IDX_LAST, VAL_W'(5));  // leaf never written
		add_req(REQ_QUERY, IDX_W'(700), IDX_W'(700), VAL_ZERO);
		add_req(REQ_QUERY, IDX_W'(5), IDX_W'(4), VAL_ONES);  // empty range
		add_req(REQ_QUERY, IDX_LAST, '0, VAL_ONES);          // empty range, widest gap
		add_req(REQ_UNUSED, '0, IDX_LAST, VAL_ONES);
		add_req(REQ_QUERY, '0, IDX_LAST, VAL_ZERO);          // unused type changed nothing
		add_req(REQ_SET, IDX_LAST, IDX_LAST, VAL_ZERO, 1'b1);
		add_req(REQ_SET, '0, '0, VAL_ZERO);
		add_req(REQ_QUERY, '0, IDX_LAST, VAL_ZERO);
		add_req(REQ_SUB, IDX_W'(511), '0, VAL_ONES);         // minus -1
		add_req(REQ_QUERY, IDX_W'(510), IDX_W'(513), VAL_ZERO);

		// random part: mostly updates and well-formed queries over a moving hot window
		for (n = 0; n < RANDOM_REQS; n++) begin
			calm = ((n / 150) % 4) == 2;
			if (n % 200 == 0)
				hot_base = IDX_W'($urandom_range(0, LEAVES - 1));
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				add_req(REQ_SET, rand_idx(), IDX_W'($urandom), rand_val(), n == 900);
			end else if (pick < 55) begin
				add_req(REQ_SUB, rand_idx(), IDX_W'($urandom), rand_val(), n == 900);
			end else if (pick < 95) begin
				a = rand_idx();
				b = rand_idx();
				qsel = $urandom_range(0, 19);
				if (qsel < 2) begin
					a = '0;
					b = IDX_LAST;
				end else if (qsel < 5) begin
					b = a + IDX_W'($urandom_range(0, 3));
				end else if (qsel < 8) begin
					// force an empty range unless both bounds agree
					if (a < b) begin
						t = a;
						a = b;
						b = t;
					end
				end else if (a > b) begin
					t = a;
					a = b;
					b = t;
				end
				add_req(REQ_QUERY, a, b, rand_val(), n == 900);
			end else begin
				add_req(REQ_UNUSED, IDX_W'($urandom), IDX_W'($urandom), rand_val(), n == 900);
			end
		end
		total = pending_reqs.size();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_reqs != total)
			@(posedge clk);
		while (sum_expect.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (errs == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- range_sum_tree_unit.f -----
hw/rtl/rsum_pkg.sv
hw/rtl/rsum_dp.sv
hw/rtl/rsum_ctrl.sv
hw/rtl/range_sum_tree_unit.sv
bench/tb_range_sum_tree_unit.sv
